@@ src/ucpd_pkg.sv @@
// ----------------------------------------------------------------------------
// USB charger port detector package
// Shared types, codes and constants of the charger port detector.
// ----------------------------------------------------------------------------
package ucpd_pkg;

    // Register file geometry: four 32-bit registers at byte addresses 4*i.
    localparam int unsigned AddrWidth = 4;
    localparam int unsigned DataWidth = 32;

    // Register indexes, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_DCD_POLL_LIMIT  = 2'd0,
        REG_DCD_RETRY_LIMIT = 2'd1,
        REG_PRIMARY_WAIT    = 2'd2,
        REG_SECONDARY_WAIT  = 2'd3
    } reg_idx_t;

    // Reset values of the registers.
    localparam logic [7:0] DcdPollLimitRst  = 8'd10;
    localparam logic [3:0] DcdRetryLimitRst = 4'd6;
    localparam logic [7:0] PrimaryWaitRst   = 8'd10;
    localparam logic [7:0] SecondaryWaitRst = 8'd1;

    // Kind of an input word.
    typedef enum logic [1:0] {
        KIND_START  = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_POWER  = 2'd3
    } kind_t;

    // Detection phase.
    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_DCD       = 2'd1,
        PH_PRIMARY   = 2'd2,
        PH_SECONDARY = 2'd3
    } phase_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_BUSY    = 2'd0,
        ST_DONE    = 2'd1,
        ST_RETRY   = 2'd2,
        ST_NOTHING = 2'd3
    } status_t;

    // Port type codes.
    localparam logic [2:0] TypeNone    = 3'd0;
    localparam logic [2:0] TypeSdp     = 3'd1;
    localparam logic [2:0] TypeDcp     = 3'd2;
    localparam logic [2:0] TypeCdp     = 3'd3;
    localparam logic [2:0] TypeAdapter = 3'd4;

    // Detector drive values.
    localparam logic [4:0] DriveDcd       = 5'h02;
    localparam logic [4:0] DrivePrimary   = 5'h0C;
    localparam logic [4:0] DriveSecondary = 5'h1C;
    localparam logic [4:0] DriveOff       = 5'h01;

    // Current limits in milliamps.
    localparam logic [10:0] ChargerMa = 11'd1500;
    localparam logic [10:0] LowMa     = 11'd100;
    localparam logic [10:0] ZeroMa    = 11'd0;

    // Configuration register values.
    typedef struct packed {
        logic [7:0] dcd_poll_limit;
        logic [3:0] dcd_retry_limit;
        logic [7:0] primary_wait_ticks;
        logic [7:0] secondary_wait_ticks;
    } cfg_t;

    // One input word.
    typedef struct packed {
        kind_t       kind;
        logic        data_contact_sense;
        logic        charger_sense;
        logic        adapter_present;
        logic [10:0] milliamps;
    } item_t;

    // One result word.
    typedef struct packed {
        logic [4:0]  detect_drive;
        logic [2:0]  cable_type;
        logic [10:0] current_ma;
        status_t     status;
        logic        cable_event;
    } result_t;

endpackage

@@ src/ucpd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Charger port detector configuration registers
// APB-style register file holding the detection limits and wait times.
// ----------------------------------------------------------------------------
module ucpd_cfg_regs
    import ucpd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [DataWidth-1:0] pwdata,
    output logic [DataWidth-1:0] prdata,
    output logic                 pready,
    output cfg_t                 cfg
);

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    // The register index comes from the word address.
    assign idx    = reg_idx_t'(paddr[AddrWidth-1:2]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Register writes in the access cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dcd_poll_limit       <= DcdPollLimitRst;
            cfg_reg.dcd_retry_limit      <= DcdRetryLimitRst;
            cfg_reg.primary_wait_ticks   <= PrimaryWaitRst;
            cfg_reg.secondary_wait_ticks <= SecondaryWaitRst;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_DCD_POLL_LIMIT:  cfg_reg.dcd_poll_limit       <= pwdata[7:0];
                REG_DCD_RETRY_LIMIT: cfg_reg.dcd_retry_limit      <= pwdata[3:0];
                REG_PRIMARY_WAIT:    cfg_reg.primary_wait_ticks   <= pwdata[7:0];
                REG_SECONDARY_WAIT:  cfg_reg.secondary_wait_ticks <= pwdata[7:0];
            endcase
        end
    end

    // Read data, zero extended to the bus width.
    always_comb
    begin
        unique case (idx)
            REG_DCD_POLL_LIMIT:  prdata = DataWidth'(cfg_reg.dcd_poll_limit);
            REG_DCD_RETRY_LIMIT: prdata = DataWidth'(cfg_reg.dcd_retry_limit);
            REG_PRIMARY_WAIT:    prdata = DataWidth'(cfg_reg.primary_wait_ticks);
            REG_SECONDARY_WAIT:  prdata = DataWidth'(cfg_reg.secondary_wait_ticks);
        endcase
    end

endmodule

@@ src/ucpd_core.sv @@
// ----------------------------------------------------------------------------
// Charger port detector core
// Detection state machine: updates the state for one word per cycle while en
// is high and forms the result word of that word.
// ----------------------------------------------------------------------------
module ucpd_core
    import ucpd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  poll_count_reg, poll_count_next;
    logic [7:0]  wait_count_reg, wait_count_next;
    logic [3:0]  retries_reg, retries_next;
    logic [2:0]  port_type_reg, port_type_next;
    logic [10:0] current_reg, current_next;
    logic [4:0]  drive_reg, drive_next;

    logic [3:0]  retries_inc;
    logic [7:0]  poll_inc;
    logic [7:0]  wait_inc;
    logic        retry_hit;
    logic        poll_hit;
    logic        primary_hit;
    logic        secondary_hit;
    status_t     status;
    logic        cable_event;

    // Counter increments and their limit compares.
    assign retries_inc   = retries_reg + 4'd1;
    assign poll_inc      = poll_count_reg + 8'd1;
    assign wait_inc      = wait_count_reg + 8'd1;
    assign retry_hit     = retries_inc >= cfg.dcd_retry_limit;
    assign poll_hit      = poll_inc >= cfg.dcd_poll_limit;
    assign primary_hit   = wait_inc >= cfg.primary_wait_ticks;
    assign secondary_hit = wait_inc >= cfg.secondary_wait_ticks;

    // Next state of the detector.
    always_comb
    begin
        phase_next      = phase_reg;
        poll_count_next = poll_count_reg;
        wait_count_next = wait_count_reg;
        retries_next    = retries_reg;
        port_type_next  = port_type_reg;
        current_next    = current_reg;
        drive_next      = drive_reg;
        unique case (item.kind)
            KIND_START:
            begin
                if (item.adapter_present)
                begin
                    port_type_next = TypeAdapter;
                    current_next   = LowMa;
                    drive_next     = DriveOff;
                    phase_next     = PH_IDLE;
                end
                else
                begin
                    drive_next      = DriveDcd;
                    poll_count_next = 8'd0;
                    phase_next      = PH_DCD;
                end
            end
            KIND_TICK:
            begin
                unique case (phase_reg)
                    PH_DCD:
                    begin
                        if (item.data_contact_sense)
                        begin
                            retries_next = retries_inc;
                            if (retry_hit)
                            begin
                                retries_next    = 4'd0;
                                drive_next      = DrivePrimary;
                                wait_count_next = 8'd0;
                                phase_next      = PH_PRIMARY;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                        else
                        begin
                            poll_count_next = poll_inc;
                            if (poll_hit)
                            begin
                                retries_next    = 4'd0;
                                drive_next      = DrivePrimary;
                                wait_count_next = 8'd0;
                                phase_next      = PH_PRIMARY;
                            end
                        end
                    end
                    PH_PRIMARY:
                    begin
                        wait_count_next = wait_inc;
                        if (primary_hit)
                        begin
                            if (item.charger_sense)
                            begin
                                drive_next      = DriveSecondary;
                                wait_count_next = 8'd0;
                                phase_next      = PH_SECONDARY;
                            end
                            else
                            begin
                                port_type_next = TypeSdp;
                                current_next   = LowMa;
                                drive_next     = DriveOff;
                                phase_next     = PH_IDLE;
                            end
                        end
                    end
                    PH_SECONDARY:
                    begin
                        wait_count_next = wait_inc;
                        if (secondary_hit)
                        begin
                            port_type_next = item.charger_sense ? TypeDcp : TypeCdp;
                            current_next   = ChargerMa;
                            drive_next     = DriveOff;
                            phase_next     = PH_IDLE;
                        end
                    end
                    PH_IDLE:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            KIND_REMOVE:
            begin
                port_type_next = TypeNone;
                current_next   = ZeroMa;
                drive_next     = DriveOff;
                phase_next     = PH_IDLE;
            end
            KIND_POWER:
            begin
                if (port_type_reg == TypeSdp)
                begin
                    current_next = item.milliamps;
                end
            end
        endcase
    end

    // Status and cable event of the word.
    always_comb
    begin
        status      = ST_NOTHING;
        cable_event = 1'b0;
        unique case (item.kind)
            KIND_START:
            begin
                if (item.adapter_present)
                begin
                    status      = ST_DONE;
                    cable_event = 1'b1;
                end
                else
                begin
                    status = ST_BUSY;
                end
            end
            KIND_TICK:
            begin
                unique case (phase_reg)
                    PH_DCD:
                    begin
                        status = (item.data_contact_sense && !retry_hit) ? ST_RETRY : ST_BUSY;
                    end
                    PH_PRIMARY:
                    begin
                        if (primary_hit && !item.charger_sense)
                        begin
                            status      = ST_DONE;
                            cable_event = 1'b1;
                        end
                        else
                        begin
                            status = ST_BUSY;
                        end
                    end
                    PH_SECONDARY:
                    begin
                        if (secondary_hit)
                        begin
                            status      = ST_DONE;
                            cable_event = 1'b1;
                        end
                        else
                        begin
                            status = ST_BUSY;
                        end
                    end
                    PH_IDLE:
                    begin
                        status = ST_NOTHING;
                    end
                endcase
            end
            KIND_REMOVE:
            begin
                status      = ST_DONE;
                cable_event = 1'b1;
            end
            KIND_POWER:
            begin
                status = (port_type_reg == TypeSdp) ? ST_DONE : ST_NOTHING;
            end
        endcase
    end

    // The result reports the state after the word.
    assign result.detect_drive = drive_next;
    assign result.cable_type   = port_type_next;
    assign result.current_ma   = current_next;
    assign result.status       = status;
    assign result.cable_event  = cable_event;

    // Detector state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            poll_count_reg <= 8'd0;
            wait_count_reg <= 8'd0;
            retries_reg    <= 4'd0;
            port_type_reg  <= TypeNone;
            current_reg    <= ZeroMa;
            drive_reg      <= 5'd0;
        end
        else if (en)
        begin
            phase_reg      <= phase_next;
            poll_count_reg <= poll_count_next;
            wait_count_reg <= wait_count_next;
            retries_reg    <= retries_next;
            port_type_reg  <= port_type_next;
            current_reg    <= current_next;
            drive_reg      <= drive_next;
        end
    end

endmodule

@@ src/usb_charger_port_detector.sv @@
// ----------------------------------------------------------------------------
// USB charger port detector
// Top level: input register, detection core, result register and the
// configuration registers.
// ----------------------------------------------------------------------------
// Usage: each input word (start, tick with comparator samples, cable removed
// or set power) gives exactly one result word with the detector drive, the
// port type, the current limit, a status code and a cable event flag.
// A word is taken when in_valid is high and in_stall is low; a result word
// is taken when out_valid is high and out_stall is low.
// The accepted word sits in the input register, and its state update loads
// the result register when the word moves on, that is when the result
// register is empty or being read.
// Throughput is one word per cycle while out_stall is low; the detection
// state is read and updated together, so a word may follow in the next cycle.
// When the receiver stalls, the result register holds its word and the
// input register still takes one more word before in_stall rises.
// Reset clears the detection state, the port type, the current limit and
// the drive value, and loads the limits with their default values.
// The user must write the limit registers over the APB-style port only while
// the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module usb_charger_port_detector
    import ucpd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [DataWidth-1:0] pwdata,
    output logic [DataWidth-1:0] prdata,
    output logic                 pready,
    // Input channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           kind,
    input  logic                 data_contact_sense,
    input  logic                 charger_sense,
    input  logic                 adapter_present,
    input  logic [10:0]          milliamps,
    // Output channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [4:0]           detect_drive,
    output logic [2:0]           cable_type,
    output logic [10:0]          current_ma,
    output logic [1:0]           status,
    output logic                 cable_event
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_vld_reg, in_vld_next;
    result_t res_reg;
    result_t res_comb;
    logic    out_vld_reg, out_vld_next;
    logic    in_take;
    logic    advance;

    // Configuration registers.
    ucpd_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // A held word moves on when the result register is empty or being read.
    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // Input register valid flag.
    always_comb
    begin
        priority if (in_take)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;
        else
            in_vld_next = in_vld_reg;
    end

    // Result register valid flag.
    always_comb
    begin
        priority if (advance)
            out_vld_next = 1'b1;
        else if (!out_stall)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Input word register.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.kind               <= kind_t'(kind);
            item_reg.data_contact_sense <= data_contact_sense;
            item_reg.charger_sense      <= charger_sense;
            item_reg.adapter_present    <= adapter_present;
            item_reg.milliamps          <= milliamps;
        end
    end

    // Detection state machine.
    ucpd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (res_comb)
    );

    // Result word register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_comb;
        end
    end

    assign out_valid    = out_vld_reg;
    assign detect_drive = res_reg.detect_drive;
    assign cable_type   = res_reg.cable_type;
    assign current_ma   = res_reg.current_ma;
    assign status       = res_reg.status;
    assign cable_event  = res_reg.cable_event;

endmodule
